// ===== hdl/iau_pkg.sv =====
package iau_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  // Number of endpoint combinations examined by product and quotient.
  localparam int unsigned NUM_CAND = 4;

endpackage

// ===== hdl/iau_div.sv =====
module iau_div #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic             clk,
  input  logic [W+F-1:0]   num_in,
  input  logic [W-1:0]     den_in,
  output logic [W+F-1:0]   quo_out,
  output logic             rem_nz
);
  import iau_pkg::*;

  localparam int unsigned NUMW = W + F;

  logic [W-1:0]    rem [NUMW+1];
  logic [NUMW-1:0] num [NUMW+1];
  logic [NUMW-1:0] quo [NUMW+1];
  logic [W-1:0]    den [NUMW+1];

  assign rem[0] = '0;
  assign num[0] = num_in;
  assign quo[0] = '0;
  assign den[0] = den_in;

  // One quotient bit per stage, most significant first. The remainder stays
  // below the divisor, which is at most 2^(W-1), so W bits hold it shifted.
  for (genvar s = 0; s < NUMW; s++) begin : g_stage
    logic [W-1:0] r2;
    logic         ge;
    assign r2 = {rem[s][W-2:0], num[s][NUMW-1]};
    assign ge = (r2 >= den[s]);
    always_ff @(posedge clk) begin
      rem[s+1] <= ge ? (r2 - den[s]) : r2;
      num[s+1] <= num[s] << 1;
      quo[s+1] <= {quo[s][NUMW-2:0], ge};
      den[s+1] <= den[s];
    end
  end

  assign quo_out = quo[NUMW];
  assign rem_nz  = (rem[NUMW] != '0);

endmodule

// ===== hdl/interval_arithmetic_unit_core.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------------
// request   | start, busy        | func, left_low, left_high, right_low, right_high
// result    | done (one cycle)   | res_low, res_high, full_range, saturated
//
// A request is taken in every cycle in which start is high; busy is always low.
// done rises once the request has passed the request register, stage 1, the quotient
// pipeline, which resolves one bit per stage, and stages A and B. Results leave in
// request order. The receiver cannot stall, so the pipeline never holds. Reset clears
// only the valid bits along the pipeline.
module interval_arithmetic_unit_core #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic signed [VALUE_WIDTH-1:0] left_low,
  input  logic signed [VALUE_WIDTH-1:0] left_high,
  input  logic signed [VALUE_WIDTH-1:0] right_low,
  input  logic signed [VALUE_WIDTH-1:0] right_high,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] res_low,
  output logic signed [VALUE_WIDTH-1:0] res_high,
  output logic                          full_range,
  output logic                          saturated
);
  import iau_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned NUMW = W + F;
  localparam int unsigned XW   = 2 * W + 2;
  localparam int unsigned NC   = NUM_CAND;

  localparam logic signed [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W:0]    SHI    = (W+1)'(VMAX) - 1;
  localparam logic signed [W:0]    SLO    = -((W+1)'(VMAX));
  localparam logic signed [XW-1:0] XHI    = XW'(VMAX) - 1;
  localparam logic signed [XW-1:0] XLO    = -(XW'(VMAX));

  assign busy = 1'b0;

  // Stage 0: request register.
  logic                s0_valid;
  func_t               s0_func;
  logic signed [W-1:0] s0_ll, s0_lh, s0_rl, s0_rh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_func <= func_t'(func);
    s0_ll   <= left_low;
    s0_lh   <= left_high;
    s0_rl   <= right_low;
    s0_rh   <= right_high;
  end

  // Stage 1: classification, sums, products and divider operands.
  logic                       c_full;
  logic signed [W-1:0]        c_sum_lo, c_sum_hi;
  logic                       c_sum_clip;
  logic [NC-1:0]              c_spec, c_spec_clip, c_neg;
  logic [NC-1:0][W-1:0]       c_spec_val;
  logic [NC-1:0][2*W-1:0]     c_prod;
  logic [NC-1:0][NUMW-1:0]    c_num;
  logic [NC-1:0][W-1:0]       c_den;

  logic signed [W-1:0] ca [NC];
  logic signed [W-1:0] cb [NC];

  assign ca[0] = s0_ll;  assign cb[0] = s0_rl;
  assign ca[1] = s0_ll;  assign cb[1] = s0_rh;
  assign ca[2] = s0_lh;  assign cb[2] = s0_rl;
  assign ca[3] = s0_lh;  assign cb[3] = s0_rh;

  function automatic logic is_inf(input logic signed [W-1:0] v);
    return (v == VMAX) || (v == VMIN);
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic signed [W-1:0] neg_bound(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    if (v == VMAX) begin
      r = VMIN;
    end else if (v == VMIN) begin
      r = VMAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // Sum of two bounds; opposite infinities give the supplied conflict code.
  function automatic logic [W:0] add_bound(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b,
                                           input logic signed [W-1:0] conflict);
    logic signed [W:0] s;
    logic              clip;
    logic signed [W-1:0] r;
    s    = (W+1)'(a) + (W+1)'(b);
    clip = 1'b0;
    if (is_inf(a) && is_inf(b) && (a != b)) begin
      r = conflict;
    end else if (is_inf(a)) begin
      r = a;
    end else if (is_inf(b)) begin
      r = b;
    end else if (s > SHI) begin
      r = VMAX;
      clip = 1'b1;
    end else if (s < SLO) begin
      r = VMIN;
      clip = 1'b1;
    end else begin
      r = s[W-1:0];
    end
    return {clip, r};
  endfunction

  logic signed [W-1:0] bl, bh;
  logic [W:0]          sum_lo_r, sum_hi_r;

  always_comb begin
    bl = (s0_func == FUNC_ADD) ? s0_rl : neg_bound(s0_rh);
    bh = (s0_func == FUNC_ADD) ? s0_rh : neg_bound(s0_rl);
    sum_lo_r   = add_bound(s0_ll, bl, VMIN);
    sum_hi_r   = add_bound(s0_lh, bh, VMAX);
    c_sum_lo   = sum_lo_r[W-1:0];
    c_sum_hi   = sum_hi_r[W-1:0];
    c_sum_clip = sum_lo_r[W] | sum_hi_r[W];
    c_full     = (s0_func == FUNC_DIV) &&
                 (((s0_rl < 0) && (s0_rh > 0)) || ((s0_rl == '0) && (s0_rh == '0)));
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      c_spec[k]      = 1'b0;
      c_spec_clip[k] = 1'b0;
      c_spec_val[k]  = '0;
      c_neg[k]       = ca[k][W-1] ^ cb[k][W-1];
      c_prod[k]      = mag(ca[k]) * mag(cb[k]);
      c_num[k]       = NUMW'(mag(ca[k])) << F;
      c_den[k]       = mag(cb[k]);
      if (s0_func == FUNC_MUL) begin
        if ((ca[k] == '0) || (cb[k] == '0)) begin
          c_spec[k] = 1'b1;
        end else if (is_inf(ca[k]) || is_inf(cb[k])) begin
          c_spec[k]     = 1'b1;
          c_spec_val[k] = (ca[k][W-1] == cb[k][W-1]) ? VMAX : VMIN;
        end
      end else begin
        if (cb[k] == '0) begin
          c_spec[k] = 1'b1;
          if (ca[k] != '0) begin
            c_spec_clip[k] = ~is_inf(ca[k]);
            c_spec_val[k]  = ca[k][W-1] ? VMIN : VMAX;
          end
        end else if (is_inf(ca[k])) begin
          c_spec[k]     = 1'b1;
          c_spec_val[k] = (ca[k][W-1] == cb[k][W-1]) ? VMAX : VMIN;
        end else if (is_inf(cb[k])) begin
          c_spec[k] = 1'b1;
        end
      end
    end
  end

  logic                    s1_valid;
  func_t                   s1_func;
  logic                    s1_full;
  logic [W-1:0]            s1_sum_lo, s1_sum_hi;
  logic                    s1_sum_clip;
  logic [NC-1:0]           s1_spec, s1_spec_clip, s1_neg;
  logic [NC-1:0][W-1:0]    s1_spec_val;
  logic [NC-1:0][2*W-1:0]  s1_prod;
  logic [NC-1:0][NUMW-1:0] s1_num;
  logic [NC-1:0][W-1:0]    s1_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_func      <= s0_func;
    s1_full      <= c_full;
    s1_sum_lo    <= c_sum_lo;
    s1_sum_hi    <= c_sum_hi;
    s1_sum_clip  <= c_sum_clip;
    s1_spec      <= c_spec;
    s1_spec_clip <= c_spec_clip;
    s1_spec_val  <= c_spec_val;
    s1_neg       <= c_neg;
    s1_prod      <= c_prod;
    s1_num       <= c_num;
    s1_den       <= c_den;
  end

  // Quotient lanes.
  logic [NC-1:0][NUMW-1:0] dv_quo;
  logic [NC-1:0]           dv_rem_nz;

  for (genvar k = 0; k < NC; k++) begin : g_div
    iau_div #(
      .W (W),
      .F (F)
    ) u_div (
      .clk     (clk),
      .num_in  (s1_num[k]),
      .den_in  (s1_den[k]),
      .quo_out (dv_quo[k]),
      .rem_nz  (dv_rem_nz[k])
    );
  end

  // Everything else travels alongside the divider.
  logic                   dl_valid     [NUMW];
  func_t                  dl_func      [NUMW];
  logic                   dl_full      [NUMW];
  logic [W-1:0]           dl_sum_lo    [NUMW];
  logic [W-1:0]           dl_sum_hi    [NUMW];
  logic                   dl_sum_clip  [NUMW];
  logic [NC-1:0]          dl_spec      [NUMW];
  logic [NC-1:0]          dl_spec_clip [NUMW];
  logic [NC-1:0]          dl_neg       [NUMW];
  logic [NC-1:0][W-1:0]   dl_spec_val  [NUMW];
  logic [NC-1:0][2*W-1:0] dl_prod      [NUMW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUMW; i++) begin
        dl_valid[i] <= 1'b0;
      end
    end else begin
      dl_valid[0] <= s1_valid;
      for (int i = 1; i < NUMW; i++) begin
        dl_valid[i] <= dl_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_func[0]      <= s1_func;
    dl_full[0]      <= s1_full;
    dl_sum_lo[0]    <= s1_sum_lo;
    dl_sum_hi[0]    <= s1_sum_hi;
    dl_sum_clip[0]  <= s1_sum_clip;
    dl_spec[0]      <= s1_spec;
    dl_spec_clip[0] <= s1_spec_clip;
    dl_neg[0]       <= s1_neg;
    dl_spec_val[0]  <= s1_spec_val;
    dl_prod[0]      <= s1_prod;
    for (int i = 1; i < NUMW; i++) begin
      dl_func[i]      <= dl_func[i-1];
      dl_full[i]      <= dl_full[i-1];
      dl_sum_lo[i]    <= dl_sum_lo[i-1];
      dl_sum_hi[i]    <= dl_sum_hi[i-1];
      dl_sum_clip[i]  <= dl_sum_clip[i-1];
      dl_spec[i]      <= dl_spec[i-1];
      dl_spec_clip[i] <= dl_spec_clip[i-1];
      dl_neg[i]       <= dl_neg[i-1];
      dl_spec_val[i]  <= dl_spec_val[i-1];
      dl_prod[i]      <= dl_prod[i-1];
    end
  end

  // Stage A: signed wide candidates, rounded toward minus infinity.
  localparam int unsigned DL = NUMW - 1;

  logic [NC-1:0][XW-1:0] ca_v;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      if (dl_func[DL] == FUNC_MUL) begin
        ca_v[k] = dl_neg[DL][k] ? XW'($signed(-XW'(dl_prod[DL][k])) >>> F)
                                : (XW'(dl_prod[DL][k]) >> F);
      end else begin
        ca_v[k] = dl_neg[DL][k] ? (-XW'(dv_quo[k]) - XW'(dv_rem_nz[k]))
                                : XW'(dv_quo[k]);
      end
    end
  end

  logic                  a_valid;
  func_t                 a_func;
  logic                  a_full;
  logic [W-1:0]          a_sum_lo, a_sum_hi;
  logic                  a_sum_clip;
  logic [NC-1:0]         a_spec, a_spec_clip;
  logic [NC-1:0][W-1:0]  a_spec_val;
  logic [NC-1:0][XW-1:0] a_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= dl_valid[DL];
    end
  end

  always_ff @(posedge clk) begin
    a_func      <= dl_func[DL];
    a_full      <= dl_full[DL];
    a_sum_lo    <= dl_sum_lo[DL];
    a_sum_hi    <= dl_sum_hi[DL];
    a_sum_clip  <= dl_sum_clip[DL];
    a_spec      <= dl_spec[DL];
    a_spec_clip <= dl_spec_clip[DL];
    a_spec_val  <= dl_spec_val[DL];
    a_v         <= ca_v;
  end

  // Stage B: special candidates take their set value; the others are clipped to the finite range.
  logic [NC-1:0][W-1:0] cb_c;
  logic [NC-1:0]        cb_clip;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      cb_clip[k] = 1'b0;
      if (a_spec[k]) begin
        cb_c[k]    = a_spec_val[k];
        cb_clip[k] = a_spec_clip[k];
      end else if ($signed(a_v[k]) > XHI) begin
        cb_c[k]    = VMAX;
        cb_clip[k] = 1'b1;
      end else if ($signed(a_v[k]) < XLO) begin
        cb_c[k]    = VMIN;
        cb_clip[k] = 1'b1;
      end else begin
        cb_c[k] = a_v[k][W-1:0];
      end
    end
  end

  logic                 b_valid;
  func_t                b_func;
  logic                 b_full;
  logic [W-1:0]         b_sum_lo, b_sum_hi;
  logic                 b_sum_clip;
  logic [NC-1:0][W-1:0] b_c;
  logic [NC-1:0]        b_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_func     <= a_func;
    b_full     <= a_full;
    b_sum_lo   <= a_sum_lo;
    b_sum_hi   <= a_sum_hi;
    b_sum_clip <= a_sum_clip;
    b_c        <= cb_c;
    b_clip     <= cb_clip;
  end

  // Stage C: choose bounds; the first candidate wins a tie.
  logic [1:0]          imin, imax;
  logic signed [W-1:0] sel_lo, sel_hi;
  logic                sel_sat;

  always_comb begin
    imin = 2'd0;
    imax = 2'd0;
    for (int i = 1; i < NC; i++) begin
      if ($signed(b_c[i]) < $signed(b_c[imin])) begin
        imin = 2'(i);
      end
      if ($signed(b_c[i]) > $signed(b_c[imax])) begin
        imax = 2'(i);
      end
    end
    unique case (b_func)
      FUNC_ADD, FUNC_SUB: begin
        sel_lo  = b_sum_lo;
        sel_hi  = b_sum_hi;
        sel_sat = b_sum_clip;
      end
      default: begin
        if (b_full) begin
          sel_lo  = VMIN;
          sel_hi  = VMAX;
          sel_sat = 1'b0;
        end else begin
          sel_lo  = b_c[imin];
          sel_hi  = b_c[imax];
          sel_sat = b_clip[imin] | b_clip[imax];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_low    <= sel_lo;
    res_high   <= sel_hi;
    full_range <= b_full;
    saturated  <= sel_sat;
  end

endmodule

// ===== test/interval_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 100ps

module interval_arithmetic_unit_core_tb;
  import iau_pkg::*;

  localparam int unsigned VW = 32;
  localparam int unsigned FB = 16;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam logic signed [VW-1:0] PINF = VW'(VMAX);
  localparam logic signed [VW-1:0] NINF = VW'(VMIN);
  localparam int unsigned LATENCY = VW + FB + 5;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    longint lo;
    longint hi;
    logic   full;
    logic   sat;
  } bounds_t;

  class interval_scoreboard;
    bounds_t pending_bounds[$];
    int      mismatches;

    function int inf_kind(longint v);
      if (v == VMAX) return 1;
      if (v == VMIN) return -1;
      return 0;
    endfunction

    function int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Finite codes run from -VMAX to VMAX-1; anything beyond is clipped.
    function longint clip_to_range(logic signed [127:0] v, inout bit clip);
      logic signed [127:0] top, bottom;
      top = 128'(VMAX - 1);
      bottom = 128'(-VMAX);
      if (v > top) begin
        clip = 1;
        return VMAX;
      end
      if (v < bottom) begin
        clip = 1;
        return VMIN;
      end
      return longint'(v);
    endfunction

    function longint flip(longint v);
      if (inf_kind(v) > 0) return VMIN;
      if (inf_kind(v) < 0) return VMAX;
      return -v;
    endfunction

    function longint add_end(longint a, longint b, longint conflict, inout bit clip);
      logic signed [127:0] s;
      int ka, kb;
      ka = inf_kind(a);
      kb = inf_kind(b);
      if (ka != 0 && kb != 0 && ka != kb) return conflict;
      if (ka != 0) return a;
      if (kb != 0) return b;
      s = 128'(a);
      s = s + 128'(b);
      return clip_to_range(s, clip);
    endfunction

    function longint mul_end(longint a, longint b, inout bit clip);
      logic signed [127:0] p, q;
      if (a == 0 || b == 0) return 0;
      if (inf_kind(a) != 0 || inf_kind(b) != 0)
        return (sign_of(a) == sign_of(b)) ? VMAX : VMIN;
      p = 128'(a);
      q = 128'(b);
      p = (p * q) >>> FB;
      return clip_to_range(p, clip);
    endfunction

    function longint div_end(longint a, longint b, inout bit clip);
      logic [127:0] num, den, quo, rem;
      logic signed [127:0] q;
      if (b == 0) begin
        if (a == 0) return 0;
        if (inf_kind(a) == 0) clip = 1;
        return (a > 0) ? VMAX : VMIN;
      end
      if (inf_kind(a) != 0) return (sign_of(a) == sign_of(b)) ? VMAX : VMIN;
      if (inf_kind(b) != 0) return 0;
      num = 128'((a < 0) ? -a : a);
      num = num << FB;
      den = 128'((b < 0) ? -b : b);
      quo = num / den;
      rem = num % den;
      q = quo;
      // Round towards minus infinity when the signs differ.
      if (sign_of(a) != sign_of(b)) begin
        q = -q;
        if (rem != 0) q = q - 1;
      end
      return clip_to_range(q, clip);
    endfunction

    function void note_request(func_t op, longint ll, longint lh, longint rl, longint rh);
      bounds_t b;
      longint cand[4];
      bit clips[4];
      bit c0, c1;
      int imin, imax;
      b.full = 0;
      b.sat = 0;
      c0 = 0;
      c1 = 0;
      if (op == FUNC_ADD || op == FUNC_SUB) begin
        b.lo = add_end(ll, (op == FUNC_ADD) ? rl : flip(rh), VMIN, c0);
        b.hi = add_end(lh, (op == FUNC_ADD) ? rh : flip(rl), VMAX, c1);
        b.sat = c0 | c1;
      end else if (op == FUNC_DIV && ((rl < 0 && rh > 0) || (rl == 0 && rh == 0))) begin
        b.lo = VMIN;
        b.hi = VMAX;
        b.full = 1;
      end else begin
        clips = '{0, 0, 0, 0};
        if (op == FUNC_MUL) begin
          cand[0] = mul_end(ll, rl, clips[0]);
          cand[1] = mul_end(ll, rh, clips[1]);
          cand[2] = mul_end(lh, rl, clips[2]);
          cand[3] = mul_end(lh, rh, clips[3]);
        end else begin
          cand[0] = div_end(ll, rl, clips[0]);
          cand[1] = div_end(ll, rh, clips[1]);
          cand[2] = div_end(lh, rl, clips[2]);
          cand[3] = div_end(lh, rh, clips[3]);
        end
        imin = 0;
        imax = 0;
        for (int i = 1; i < 4; i++) begin
          if (cand[i] < cand[imin]) imin = i;
          if (cand[i] > cand[imax]) imax = i;
        end
        b.lo = cand[imin];
        b.hi = cand[imax];
        b.sat = clips[imin] | clips[imax];
      end
      pending_bounds = {pending_bounds, b};
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic signed [VW-1:0] lo, logic signed [VW-1:0] hi,
                      logic full, logic sat);
      bounds_t e;
      if (pending_bounds.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = pending_bounds.pop_front();
      if (longint'(lo) !== e.lo) report($sformatf("res_low %0d, expected %0d", lo, e.lo));
      if (longint'(hi) !== e.hi) report($sformatf("res_high %0d, expected %0d", hi, e.hi));
      if (full !== e.full) report($sformatf("full_range %b, expected %b", full, e.full));
      if (sat !== e.sat) report($sformatf("saturated %b, expected %b", sat, e.sat));
    endtask
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] func;
  logic signed [VW-1:0] left_low, left_high, right_low, right_high;
  logic done;
  logic signed [VW-1:0] res_low, res_high;
  logic full_range, saturated;

  interval_scoreboard board;
  int idle_pct;
  int quiet_cycles;

  interval_arithmetic_unit_core #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .left_low(left_low), .left_high(left_high), .right_low(right_low),
    .right_high(right_high), .done(done), .res_low(res_low), .res_high(res_high),
    .full_range(full_range), .saturated(saturated)
  );

  initial clk = 0;
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        board.note_request(func_t'(func), longint'(left_low), longint'(left_high),
                           longint'(right_low), longint'(right_high));
      if (done) board.check_result(res_low, res_high, full_range, saturated);
    end
  end

  // Ends the run if neither requests nor results move for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("interval_arithmetic_unit_core regression: fail");
        $finish;
      end
    end
  end

  task send_request(func_t op, logic signed [VW-1:0] ll, logic signed [VW-1:0] lh,
                    logic signed [VW-1:0] rl, logic signed [VW-1:0] rh);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    func <= op;
    left_low <= ll;
    left_high <= lh;
    right_low <= rl;
    right_high <= rh;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function logic signed [VW-1:0] pick_value();
    logic signed [VW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3: v = $urandom_range(0, 8 << FB);
      4: v = -$signed({1'b0, 31'($urandom_range(0, 8 << FB))});
      5: v = $urandom_range(1) ? PINF : NINF;
      6: v = 0;
      7: v = ($urandom_range(1) ? 1 : -1) * ($urandom_range(1, 300) << FB);
      8: v = $urandom_range(1) ? PINF - VW'($urandom_range(0, 3))
                               : NINF + VW'($urandom_range(0, 3));
      default: v = $urandom_range(0, 15) - 8;
    endcase
    return v;
  endfunction

  task send_random();
    logic signed [VW-1:0] a, b, c, d, t;
    a = pick_value();
    b = pick_value();
    c = pick_value();
    d = pick_value();
    // Mostly well-ordered intervals; a few are left reversed on purpose.
    if ($urandom_range(9) != 0) begin
      if (a > b) begin t = a; a = b; b = t; end
      if (c > d) begin t = c; c = d; d = t; end
    end
    send_request(func_t'($urandom_range(3)), a, b, c, d);
  endtask

  initial begin
    board = new();
    rst = 1;
    start = 0;
    func = FUNC_ADD;
    left_low = 0;
    left_high = 0;
    right_low = 0;
    right_high = 0;
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_request(FUNC_ADD, 32'sh0001_0000, 32'sh0002_0000, -32'sh0000_8000, 32'sh0003_0000);
    send_request(FUNC_ADD, NINF, PINF, PINF, NINF);
    send_request(FUNC_ADD, PINF - 1, NINF + 1, PINF - 1, NINF + 1);
    send_request(FUNC_SUB, 32'sh0005_0000, 32'sh0007_0000, 32'sh0001_0000, 32'sh0002_0000);
    send_request(FUNC_SUB, NINF, PINF, NINF, PINF);
    send_request(FUNC_SUB, NINF + 1, PINF - 1, PINF - 1, NINF + 1);
    send_request(FUNC_MUL, -32'sh0002_0000, 32'sh0003_0000, -32'sh0001_8000, 32'sh0004_0000);
    send_request(FUNC_MUL, 0, PINF, NINF, 0);
    send_request(FUNC_MUL, NINF, PINF, -32'sh0001_0000, 32'sh0001_0000);
    send_request(FUNC_MUL, PINF - 1, NINF + 1, PINF - 1, NINF + 1);
    send_request(FUNC_MUL, -1, 1, 1, 3);
    send_request(FUNC_DIV, 32'sh0001_0000, 32'sh0002_0000, -1, 1);
    send_request(FUNC_DIV, 32'sh0001_0000, 32'sh0002_0000, 0, 0);
    send_request(FUNC_DIV, 32'sh0001_0000, -32'sh0002_0000, 0, 32'sh0002_0000);
    send_request(FUNC_DIV, 0, PINF, -32'sh0003_0000, 0);
    send_request(FUNC_DIV, NINF, PINF, 32'sh0002_0000, PINF);
    send_request(FUNC_DIV, 32'sh0007_0000, -32'sh0007_0000, 3, 7);
    send_request(FUNC_DIV, PINF - 1, NINF + 1, 1, -1);
    send_request(FUNC_DIV, 1, -1, 32'sh0003_0000, -32'sh0003_0000);
    send_request(FUNC_DIV, NINF, PINF, NINF, 0);

    idle_pct = 27;
    repeat (410) send_random();
    idle_pct = 61;
    repeat (410) send_random();
    idle_pct = 0;
    repeat (410) send_random();
    start <= 0;

    while (board.pending_bounds.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0)
      $display("interval_arithmetic_unit_core regression: pass");
    else
      $display("interval_arithmetic_unit_core regression: fail");
    $finish;
  end

endmodule
